@@ sv/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, codes and types of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int LINE_BITS   = 16;

    localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]  LINE_ONE  = LINE_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(STACK_DEPTH);

    localparam logic [7:0] CH_OPEN_P  = 8'h28;
    localparam logic [7:0] CH_CLOSE_P = 8'h29;
    localparam logic [7:0] CH_OPEN_B  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_B = 8'h7D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NONE    = 8'h00;

    typedef enum logic [1:0] {
        VERDICT_PASS     = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_UNCLOSED = 2'd2,
        VERDICT_OVERFLOW = 2'd3
    } verdict_t;

    // One stacked opener: kind is 0 for a parenthesis, 1 for a brace.
    typedef struct packed {
        logic                 kind;
        logic [LINE_BITS-1:0] line;
    } stack_entry_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        stack_entry_t         data;
    } stack_wr_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  bracket_char;
        logic [15:0] line_number;
    } result_t;

endpackage

@@ sv/bbc_stack_ram.sv @@
// ----------------------------------------------------------------------------
// bbc_stack_ram
// Opener stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbc_stack_ram (
    input  logic                          clk,
    input  bbc_pkg::stack_wr_t            wr,
    input  logic [bbc_pkg::ADDR_BITS-1:0] rd_addr,
    output bbc_pkg::stack_entry_t         rd_data
);
    import bbc_pkg::*;

    stack_entry_t mem [STACK_DEPTH];
    stack_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bbc_scan.sv @@
// ----------------------------------------------------------------------------
// bbc_scan
// Per-byte scanner: quote mode, line counter, sticky error, stack pointer and
// a cached top-of-stack entry in front of the stack memory.
// ----------------------------------------------------------------------------
module bbc_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            text_byte,
    input  logic                  final_byte,
    input  bbc_pkg::stack_entry_t rd_data,
    output bbc_pkg::stack_wr_t    wr,
    output logic [bbc_pkg::ADDR_BITS-1:0] rd_addr,
    output bbc_pkg::result_t      result
);
    import bbc_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  quote_reg, quote_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic                  err_reg, err_next;
    verdict_t              err_verdict_reg, err_verdict_next;
    logic [7:0]            err_char_reg, err_char_next;
    logic [LINE_BITS-1:0]  err_line_reg, err_line_next;
    stack_entry_t          top_reg, top_next;

    logic is_opener;
    logic is_closer;
    logic closer_kind;
    logic [COUNT_BITS-1:0] below_top;

    assign is_opener   = (text_byte == CH_OPEN_P) || (text_byte == CH_OPEN_B);
    assign is_closer   = (text_byte == CH_CLOSE_P) || (text_byte == CH_CLOSE_B);
    assign closer_kind = (text_byte == CH_CLOSE_B);

    always_comb
    begin
        count_next       = count_reg;
        quote_next       = quote_reg;
        line_next        = line_reg;
        err_next         = err_reg;
        err_verdict_next = err_verdict_reg;
        err_char_next    = err_char_reg;
        err_line_next    = err_line_reg;
        top_next         = top_reg;
        wr               = '0;
        result           = '0;

        if (accept)
        begin
            if (!err_reg)
            begin
                if (text_byte == CH_QUOTE)
                begin
                    quote_next = !quote_reg;
                end
                else if (!quote_reg && is_opener)
                begin
                    if (count_reg >= COUNT_FULL)
                    begin
                        err_next         = 1'b1;
                        err_verdict_next = VERDICT_OVERFLOW;
                        err_char_next    = text_byte;
                        err_line_next    = line_reg;
                    end
                    else
                    begin
                        wr.en        = 1'b1;
                        wr.addr      = count_reg[ADDR_BITS-1:0];
                        wr.data.kind = (text_byte == CH_OPEN_B);
                        wr.data.line = line_reg;
                        top_next     = wr.data;
                        count_next   = count_reg + COUNT_BITS'(1);
                    end
                end
                else if (!quote_reg && is_closer)
                begin
                    if ((count_reg != '0) && (top_reg.kind == closer_kind))
                    begin
                        // The entry below the top was prefetched last cycle.
                        count_next = count_reg - COUNT_BITS'(1);
                        top_next   = rd_data;
                    end
                    else
                    begin
                        err_next         = 1'b1;
                        err_verdict_next = VERDICT_MISMATCH;
                        err_char_next    = text_byte;
                        err_line_next    = line_reg;
                    end
                end
            end

            if ((text_byte == CH_NEWLINE) && (line_reg != LINE_MAX))
            begin
                line_next = line_reg + LINE_BITS'(1);
            end

            if (final_byte)
            begin
                if (err_next)
                begin
                    result.verdict      = err_verdict_next;
                    result.bracket_char = err_char_next;
                    result.line_number  = 16'(err_line_next);
                end
                else if (count_next != '0)
                begin
                    result.verdict      = VERDICT_UNCLOSED;
                    result.bracket_char = top_next.kind ? CH_OPEN_B : CH_OPEN_P;
                    result.line_number  = 16'(top_next.line);
                end
                else
                begin
                    result.verdict      = VERDICT_PASS;
                    result.bracket_char = CH_NONE;
                    result.line_number  = '0;
                end

                count_next = '0;
                quote_next = 1'b0;
                line_next  = LINE_ONE;
                err_next   = 1'b0;
            end
        end
    end

    // Keep the entry just below the new top in flight every cycle, so that a
    // pop can take its replacement top without waiting.
    assign below_top = count_next - COUNT_BITS'(2);
    assign rd_addr   = below_top[ADDR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            quote_reg <= 1'b0;
            line_reg  <= LINE_ONE;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            quote_reg <= quote_next;
            line_reg  <= line_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_verdict_reg <= err_verdict_next;
        err_char_reg    <= err_char_next;
        err_line_reg    <= err_line_next;
        top_reg         <= top_next;
    end

endmodule

@@ sv/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks nesting of parentheses and braces in a byte stream, one result for
// each text, with a memory-backed opener stack.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  text      text_valid / text_stall    text_byte, final_byte
//  result    result_valid / result_stall verdict, bracket_char, line_number
//
// One byte is accepted every cycle unless a final byte is stalled; the cached
// top entry plus a registered stack read of the entry below it keeps pushes and pops at full rate.
// The result appears in the cycle after the final byte is accepted.
// Ordinary bytes keep flowing while a result waits; only a final byte is
// stalled while an earlier result is still held.
// Reset clears the counters and flags; the stack memory needs no clearing.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  logic [7:0]          text_byte,
    input  logic                final_byte,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          verdict,
    output logic [7:0]          bracket_char,
    output logic [15:0]         line_number
);
    import bbc_pkg::*;

    logic                 accept;
    stack_wr_t            wr;
    logic [ADDR_BITS-1:0] rd_addr;
    stack_entry_t         rd_data;
    result_t              result;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_result_reg;

    assign text_stall = out_valid_reg && result_stall && final_byte;
    assign accept     = text_valid && !text_stall;

    bbc_stack_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbc_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .rd_data    (rd_data),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .result     (result)
    );

    always_comb
    begin
        priority if (accept && final_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && final_byte)
        begin
            out_result_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign verdict      = out_result_reg.verdict;
    assign bracket_char = out_result_reg.bracket_char;
    assign line_number  = out_result_reg.line_number;

endmodule

@@ sv/bbc_checker.sv @@
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the bracket balance checker, bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        text_valid,
    input logic        text_stall,
    input logic [7:0]  text_byte,
    input logic        final_byte,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  verdict,
    input logic [7:0]  bracket_char,
    input logic [15:0] line_number
);
    import bbc_pkg::*;

    // A held result keeps its fields until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(verdict)
            && $stable(bracket_char) && $stable(line_number))
        else $error("result changed while stalled");

    // A new result must follow an accepted final byte.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid && result_stall)
            |-> $past(text_valid && !text_stall && final_byte))
        else $error("result without a final byte");

    a_pass_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict == VERDICT_PASS)
            |-> (bracket_char == CH_NONE) && (line_number == 16'd0))
        else $error("pass carries a character or line");

    // Errors and unclosed openers always name a real line.
    a_error_line: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict != VERDICT_PASS) |-> (line_number != 16'd0))
        else $error("error reported on line zero");

    a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict == VERDICT_MISMATCH)
            |-> (bracket_char == CH_CLOSE_P) || (bracket_char == CH_CLOSE_B))
        else $error("mismatch names a non-closer");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

@@ test/tb_bracket_balance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker
// Sends texts byte by byte through the text channel, predicts the verdict of
// each text with an independent bracket stack, and compares every result
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;

    import bbc_pkg::*;

    class balance_scoreboard;
        logic                 kind_stack [STACK_DEPTH];
        logic [LINE_BITS-1:0] opener_line [STACK_DEPTH];
        int unsigned          depth;
        bit                   in_string;
        logic [LINE_BITS-1:0] line_no;
        bit                   error_held;
        result_t              held_error;
        result_t              pending_verdicts [$];
        int unsigned          errors;
        int unsigned          verdict_seen [4];

        function new();
            clear_text();
        endfunction

        function void clear_text();
            depth      = 0;
            in_string  = 1'b0;
            line_no    = LINE_ONE;
            error_held = 1'b0;
            held_error = '0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function void hold_error(verdict_t v, logic [7:0] ch);
            error_held              = 1'b1;
            held_error.verdict      = v;
            held_error.bracket_char = ch;
            held_error.line_number  = 16'(line_no);
        endfunction

        // Predicts the effect of one accepted byte and, on the last byte of
        // a text, queues the verdict that the block must return.
        function void note_request(logic [7:0] b, logic last);
            result_t res;
            if (!error_held)
            begin
                if (b == CH_QUOTE)
                    in_string = !in_string;
                else if (!in_string)
                begin
                    if (b == CH_OPEN_P || b == CH_OPEN_B)
                    begin
                        if (depth >= STACK_DEPTH)
                            hold_error(VERDICT_OVERFLOW, b);
                        else
                        begin
                            kind_stack[depth]  = (b == CH_OPEN_B);
                            opener_line[depth] = line_no;
                            depth++;
                        end
                    end
                    else if (b == CH_CLOSE_P || b == CH_CLOSE_B)
                    begin
                        if (depth > 0 && kind_stack[depth-1] == (b == CH_CLOSE_B))
                            depth--;
                        else
                            hold_error(VERDICT_MISMATCH, b);
                    end
                end
            end
            // The line counter runs on in string mode and after an error.
            if (b == CH_NEWLINE && line_no != LINE_MAX)
                line_no++;
            if (last)
            begin
                if (error_held)
                    res = held_error;
                else if (depth > 0)
                begin
                    res.verdict      = VERDICT_UNCLOSED;
                    res.bracket_char = kind_stack[depth-1] ? CH_OPEN_B : CH_OPEN_P;
                    res.line_number  = 16'(opener_line[depth-1]);
                end
                else
                begin
                    res.verdict      = VERDICT_PASS;
                    res.bracket_char = CH_NONE;
                    res.line_number  = 16'd0;
                end
                pending_verdicts.push_back(res);
                clear_text();
            end
        endfunction

        function void check_result(logic [1:0] v, logic [7:0] ch, logic [15:0] ln);
            result_t want;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: verdict %0d char %h line %0d",
                                 v, ch, ln));
                return;
            end
            want = pending_verdicts.pop_front();
            verdict_seen[want.verdict]++;
            if (2'(want.verdict) !== v)
                report($sformatf("verdict: expected %0d, got %0d", want.verdict, v));
            if (want.bracket_char !== ch)
                report($sformatf("bracket_char: expected %h, got %h", want.bracket_char, ch));
            if (want.line_number !== ln)
                report($sformatf("line_number: expected %0d, got %0d", want.line_number, ln));
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        text_valid   = 1'b0;
    logic        text_stall;
    logic [7:0]  text_byte    = 8'h00;
    logic        final_byte   = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  verdict;
    logic [7:0]  bracket_char;
    logic [15:0] line_number;

    balance_scoreboard sb = new();
    logic [7:0]        text_q [$];
    int unsigned       bytes_sent;
    int unsigned       texts_sent;

    bracket_balance_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict),
        .bracket_char (bracket_char),
        .line_number  (line_number)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20000000;
        $display("Run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && !text_stall)
                sb.note_request(text_byte, final_byte);
            if (result_valid && !result_stall)
                sb.check_result(verdict, bracket_char, line_number);
        end
    end

    // Result side: runs of stall and of no stall, mostly short, a few long.
    initial
    begin
        int  run_left;
        bit  stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left > 0)
                run_left--;
            else
            begin
                stall_now = ($urandom_range(0, 99) < 30);
                if (stall_now)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                           : $urandom_range(0, 2);
                else
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(0, 7);
            end
            result_stall <= stall_now;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit no_idle);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        final_byte <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input bit no_idle);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1, no_idle);
        text_q.delete();
        texts_sent++;
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_repeat(input logic [7:0] b, input int n);
        repeat (n) text_q.push_back(b);
    endtask

    task automatic directed_text(input string s);
        add_string(s);
        send_text($urandom_range(0, 1));
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == CH_QUOTE || b == CH_OPEN_P || b == CH_CLOSE_P ||
            b == CH_OPEN_B || b == CH_CLOSE_B)
            b = "x";
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] specials [6];
        specials = '{CH_OPEN_P, CH_CLOSE_P, CH_OPEN_B, CH_CLOSE_B, CH_QUOTE, CH_NEWLINE};
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 255));
        return specials[$urandom_range(0, 5)];
    endfunction

    // Mostly well-nested texts with random content; some carry a wrong
    // closer, leave openers unclosed or end with a stray closer, and a
    // quarter are plain noise.
    task automatic build_random_text();
        int  target;
        int  r;
        bit  twist;
        bit  kinds [$];
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(1, 30);
        if ($urandom_range(0, 99) < 25)
        begin
            repeat (target) text_q.push_back(noise_byte());
            return;
        end
        twist = ($urandom_range(0, 99) < 15);
        while (text_q.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if (kinds.size() < 12)
                    begin
                        kinds.push_back($urandom_range(0, 1));
                        text_q.push_back(kinds[$] ? CH_OPEN_B : CH_OPEN_P);
                    end
                end
                2, 3:
                begin
                    if (kinds.size() > 0)
                    begin
                        if (twist && $urandom_range(0, 2) == 0)
                        begin
                            text_q.push_back(kinds[$] ? CH_CLOSE_P : CH_CLOSE_B);
                            twist = 1'b0;
                        end
                        else
                            text_q.push_back(kinds[$] ? CH_CLOSE_B : CH_CLOSE_P);
                        void'(kinds.pop_back());
                    end
                end
                4:
                begin
                    text_q.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        r = $urandom_range(0, 5);
                        case (r)
                            0: text_q.push_back(CH_OPEN_P);
                            1: text_q.push_back(CH_CLOSE_B);
                            2: text_q.push_back(CH_NEWLINE);
                            default: text_q.push_back(filler_byte());
                        endcase
                    end
                    text_q.push_back(CH_QUOTE);
                end
                5:
                    text_q.push_back(CH_NEWLINE);
                default:
                    text_q.push_back(filler_byte());
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 88)
        begin
            // Close everything except where the text is meant to stay open.
            while (kinds.size() > 0 && (r < 75 || $urandom_range(0, 2) == 0))
                text_q.push_back(kinds.pop_back() ? CH_CLOSE_B : CH_CLOSE_P);
        end
        else
        begin
            while (kinds.size() > 0)
                text_q.push_back(kinds.pop_back() ? CH_CLOSE_B : CH_CLOSE_P);
            text_q.push_back($urandom_range(0, 1) ? CH_CLOSE_B : CH_CLOSE_P);
        end
        if (text_q.size() == 0)
            text_q.push_back(filler_byte());
    endtask

    initial
    begin
        int wait_cycles;
        bytes_sent = 0;
        texts_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: pass, mismatch and unclosed verdicts, quoting, line counting, odd bytes.
        text_q.push_back(CH_NONE);
        send_text(1'b0);
        directed_text("(\n{a})");
        directed_text("(}");
        directed_text("\n)");
        directed_text("\n\n{(");
        directed_text("\"(}\"{}");
        directed_text("\"{\n");
        directed_text(")\n(\n}");
        directed_text("{\n\n}");
        text_q.push_back(8'hFF);
        text_q.push_back(CH_OPEN_B);
        text_q.push_back(8'h80);
        send_text(1'b0);

        // A full stack, then one opener too many.
        text_q.push_back(CH_NEWLINE);
        add_repeat(CH_OPEN_P, STACK_DEPTH);
        add_string("{)\n}");
        send_text(1'b0);

        while (bytes_sent < 2000)
        begin
            build_random_text();
            send_text($urandom_range(0, 4) == 0);
        end
        text_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_verdicts.size() > 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending_verdicts.size() > 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));

        $display("Sent %0d texts in %0d bytes with random idling on both channels.",
                 texts_sent, bytes_sent);
        $display("Verdicts checked: %0d pass, %0d mismatch, %0d unclosed, %0d overflow.",
                 sb.verdict_seen[0], sb.verdict_seen[1], sb.verdict_seen[2],
                 sb.verdict_seen[3]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d failures in total", sb.errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
